### rtl/core/stq_pkg.sv
// stq_pkg: shared widths, cell operation codes and the cell control struct
// for the sorted timer queue. No dependencies.
package stq_pkg;

	localparam int ID_W        = 4;
	localparam int ID_SPAN     = 2 ** ID_W;
	localparam int PERIOD_W    = 32;
	localparam int COUNT_W     = 16;
	localparam int CMD_W       = 2;
	localparam int FIRE_TIME_W = 48;

	// operation applied to every cell of the chain in the same cycle
	typedef enum logic [2:0] {
		CELL_HOLD    = 3'd0,
		CELL_KILL    = 3'd1,
		CELL_SQUEEZE = 3'd2,
		CELL_INSERT  = 3'd3,
		CELL_POP     = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t        op;
		logic [ID_W-1:0] id;
	} cell_ctrl_t;

endpackage

### rtl/core/sorted_timer_queue_unit.sv
// sorted_timer_queue_unit: up to 16 timers held in a chain of cells sorted by expiry.
// Tick: busy in CHECK, then FIRE on a pop, then SQUEEZE on requeue; FIRE registers any strobe.
// Start: busy in SQUEEZE while the old entry's hole walks the chain, then inserts the new entry.
// Stop and unused commands leave the unit idle. Results cannot be held off by the receiver.
// Async reset clears time, the queue and the sequencer; timer stores need no clearing.
module sorted_timer_queue_unit
	import stq_pkg::*;
#(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [CMD_W-1:0]       command,
	input  logic [ID_W-1:0]        timer_id,
	input  logic [PERIOD_W-1:0]    period_ms,
	input  logic [PERIOD_W-1:0]    delay_ms,
	input  logic signed [COUNT_W-1:0] repeat_count,
	output logic                   done,
	output logic [ID_W-1:0]        fired_timer,
	output logic [FIRE_TIME_W-1:0] fire_time,
	output logic                   went_idle
);

	localparam int Q_DEPTH = (NUM_TIMERS < ID_SPAN) ? NUM_TIMERS : ID_SPAN;
	localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_SQUEEZE = 4'b0010,
		ST_CHECK   = 4'b0100,
		ST_FIRE    = 4'b1000
	} seq_state_t;

	seq_state_t state_q;
	logic [TIME_BITS-1:0]   time_q;
	logic [TIME_BITS-1:0]   exp_q;
	logic [ID_W-1:0]        ins_id_q;
	logic [ID_W-1:0]        fire_id_q;
	logic                   done_q;
	logic [ID_W-1:0]        fired_q;
	logic [FIRE_TIME_W-1:0] fire_time_q;
	logic                   went_q;

	logic                 c_valid [Q_DEPTH];
	logic                 c_dead  [Q_DEPTH];
	logic                 c_gt    [Q_DEPTH];
	logic [ID_W-1:0]      c_id    [Q_DEPTH];
	logic [TIME_BITS-1:0] c_exp   [Q_DEPTH];
	logic [Q_DEPTH-1:0]   dead_vec;
	logic                 any_dead;
	cell_ctrl_t           cell_ctrl;

	logic                accept, id_ok, start_ok, stop_ok, tick_acc, head_due;
	logic [PERIOD_W-1:0] first_wait;
	logic [PERIOD_W-1:0] rd_int;
	logic [COUNT_W-1:0]  rd_rem, rem_next, wr_rem;
	logic                rem_zero, rem_forever, last_fire;
	logic                wr_int_en, wr_rem_en;
	logic [IDX_W-1:0]    wr_idx;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign id_ok    = (int'(timer_id) < NUM_TIMERS);
	assign start_ok = accept && (command == CMD_START) && id_ok && (repeat_count != '0);
	assign stop_ok  = accept && (command == CMD_STOP) && id_ok;
	assign tick_acc = accept && (command == CMD_TICK);

	assign first_wait = (delay_ms != '0) ? delay_ms : period_ms;
	assign head_due   = c_valid[0] && (c_exp[0] <= time_q);

	always_comb begin
		for (int k = 0; k < Q_DEPTH; k++) begin
			dead_vec[k] = c_dead[k];
		end
	end
	assign any_dead = |dead_vec;

	// count of the popped timer: top bit set means it never runs out
	assign rem_zero    = (rd_rem == '0);
	assign rem_forever = rd_rem[COUNT_W-1];
	assign rem_next    = rd_rem - COUNT_W'(1);
	assign last_fire   = !rem_forever && (rd_rem == COUNT_W'(1));

	always_comb begin
		cell_ctrl.op = CELL_HOLD;
		cell_ctrl.id = ins_id_q;
		priority if (start_ok) begin
			cell_ctrl.op = CELL_KILL;
			cell_ctrl.id = timer_id;
		end else if (state_q == ST_SQUEEZE) begin
			cell_ctrl.op = any_dead ? CELL_SQUEEZE : CELL_INSERT;
		end else if ((state_q == ST_CHECK) && head_due) begin
			cell_ctrl.op = CELL_POP;
		end else begin
			cell_ctrl.op = CELL_HOLD;
		end
	end

	genvar i;
	for (i = 0; i < Q_DEPTH; i++) begin : g_cell
		logic                 l_valid, l_dead, l_gt, r_valid;
		logic [ID_W-1:0]      l_id, r_id;
		logic [TIME_BITS-1:0] l_exp, r_exp;

		if (i == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_dead  = 1'b0;
			assign l_gt    = 1'b0;
			assign l_id    = '0;
			assign l_exp   = '0;
		end else begin : g_left
			assign l_valid = c_valid[i-1];
			assign l_dead  = c_dead[i-1];
			assign l_gt    = c_gt[i-1];
			assign l_id    = c_id[i-1];
			assign l_exp   = c_exp[i-1];
		end

		if (i == Q_DEPTH - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_id    = '0;
			assign r_exp   = '0;
		end else begin : g_right
			assign r_valid = c_valid[i+1];
			assign r_id    = c_id[i+1];
			assign r_exp   = c_exp[i+1];
		end

		stq_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.new_exp     (exp_q),
			.left_valid  (l_valid),
			.left_dead   (l_dead),
			.left_gt     (l_gt),
			.left_id     (l_id),
			.left_exp    (l_exp),
			.right_valid (r_valid),
			.right_id    (r_id),
			.right_exp   (r_exp),
			.valid       (c_valid[i]),
			.dead        (c_dead[i]),
			.gt          (c_gt[i]),
			.id          (c_id[i]),
			.expiry      (c_exp[i])
		);
	end

	assign wr_int_en = start_ok;
	assign wr_rem_en = start_ok || stop_ok ||
		((state_q == ST_FIRE) && !rem_zero && !rem_forever);
	assign wr_idx    = (state_q == ST_FIRE) ? IDX_W'(fire_id_q) : IDX_W'(timer_id);
	assign wr_rem    = start_ok ? unsigned'(repeat_count) : (stop_ok ? '0 : rem_next);

	stq_timer_mem #(
		.NUM_TIMERS (NUM_TIMERS),
		.IDX_W      (IDX_W)
	) u_mem (
		.clk       (clk),
		.wr_int_en (wr_int_en),
		.wr_rem_en (wr_rem_en),
		.wr_idx    (wr_idx),
		.wr_int    (period_ms),
		.wr_rem    (wr_rem),
		.rd_idx    (IDX_W'(c_id[0])),
		.rd_int    (rd_int),
		.rd_rem    (rd_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			time_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						time_q  <= time_q + TIME_BITS'(1);
						state_q <= ST_CHECK;
					end else if (start_ok) begin
						state_q <= ST_SQUEEZE;
					end
				end
				ST_SQUEEZE: begin
					// insertion happens in the first cycle with no hole left
					if (!any_dead) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHECK: begin
					state_q <= head_due ? ST_FIRE : ST_IDLE;
				end
				ST_FIRE: begin
					if (rem_zero) begin
						state_q <= ST_IDLE;
					end else begin
						done_q  <= 1'b1;
						state_q <= last_fire ? ST_IDLE : ST_SQUEEZE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_ok) begin
			ins_id_q <= timer_id;
			exp_q    <= time_q + TIME_BITS'(first_wait);
		end
		if (state_q == ST_CHECK) begin
			fire_id_q <= c_id[0];
		end
		if (state_q == ST_FIRE) begin
			ins_id_q    <= fire_id_q;
			exp_q       <= time_q + TIME_BITS'(rd_int);
			fired_q     <= fire_id_q;
			went_q      <= last_fire;
			fire_time_q <= FIRE_TIME_W'(time_q);
		end
	end

	assign done        = done_q;
	assign fired_timer = fired_q;
	assign fire_time   = fire_time_q;
	assign went_idle   = went_q;

	a_done_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIRE))
		else $error("result strobe without a firing step");

	a_hole_only_in_squeeze: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SQUEEZE) |-> (dead_vec == '0))
		else $error("dead queue slot outside squeeze");

	a_tick_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> (state_q == ST_CHECK))
		else $error("tick request did not reach the head check");

	for (genvar k = 0; k < Q_DEPTH - 1; k++) begin : g_order_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			c_valid[k+1] |-> (c_valid[k] && (c_exp[k] <= c_exp[k+1])))
			else $error("queue chain not packed and sorted");
	end

endmodule

### rtl/core/stq_cell.sv
// stq_cell: one slot of the sorted expiry chain, holding a timer id and its
// expiry time. Depends on stq_pkg.
module stq_cell
	import stq_pkg::*;
#(
	parameter int TIME_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [TIME_BITS-1:0] new_exp,
	input  logic                 left_valid,
	input  logic                 left_dead,
	input  logic                 left_gt,
	input  logic [ID_W-1:0]      left_id,
	input  logic [TIME_BITS-1:0] left_exp,
	input  logic                 right_valid,
	input  logic [ID_W-1:0]      right_id,
	input  logic [TIME_BITS-1:0] right_exp,
	output logic                 valid,
	output logic                 dead,
	output logic                 gt,
	output logic [ID_W-1:0]      id,
	output logic [TIME_BITS-1:0] expiry
);

	logic                 valid_q, dead_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] exp_q;
	logic                 valid_d, dead_d;
	logic [ID_W-1:0]      id_d;
	logic [TIME_BITS-1:0] exp_d;

	// an empty slot counts as later than any new entry; a new entry goes behind equal expiries
	assign gt = !valid_q || (exp_q > new_exp);

	always_comb begin
		valid_d = valid_q;
		dead_d  = dead_q;
		id_d    = id_q;
		exp_d   = exp_q;
		unique case (ctrl.op)
			CELL_HOLD: begin
			end
			CELL_KILL: begin
				if (valid_q && (id_q == ctrl.id)) begin
					dead_d = 1'b1;
				end
			end
			CELL_SQUEEZE: begin
				// the dead slot swaps with its right neighbour, moving the hole to the tail
				if (dead_q) begin
					valid_d = right_valid;
					dead_d  = 1'b0;
					id_d    = right_id;
					exp_d   = right_exp;
				end else if (left_dead && valid_q) begin
					dead_d = 1'b1;
				end
			end
			CELL_INSERT: begin
				if (gt) begin
					if (left_gt) begin
						valid_d = left_valid;
						id_d    = left_id;
						exp_d   = left_exp;
					end else begin
						valid_d = 1'b1;
						id_d    = ctrl.id;
						exp_d   = new_exp;
					end
				end
			end
			CELL_POP: begin
				valid_d = right_valid;
				dead_d  = 1'b0;
				id_d    = right_id;
				exp_d   = right_exp;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dead_q  <= 1'b0;
		end else begin
			valid_q <= valid_d;
			dead_q  <= dead_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q  <= id_d;
		exp_q <= exp_d;
	end

	assign valid  = valid_q;
	assign dead   = dead_q;
	assign id     = id_q;
	assign expiry = exp_q;

endmodule

### rtl/core/stq_timer_mem.sv
// stq_timer_mem: per-timer period and remaining-count store, one write port
// and one registered read port. Depends on stq_pkg.
module stq_timer_mem
	import stq_pkg::*;
#(
	parameter int NUM_TIMERS = 16,
	parameter int IDX_W      = 4
) (
	input  logic                clk,
	input  logic                wr_int_en,
	input  logic                wr_rem_en,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic [PERIOD_W-1:0] wr_int,
	input  logic [COUNT_W-1:0]  wr_rem,
	input  logic [IDX_W-1:0]    rd_idx,
	output logic [PERIOD_W-1:0] rd_int,
	output logic [COUNT_W-1:0]  rd_rem
);

	logic [PERIOD_W-1:0] int_mem [NUM_TIMERS];
	logic [COUNT_W-1:0]  rem_mem [NUM_TIMERS];
	logic [PERIOD_W-1:0] rd_int_q;
	logic [COUNT_W-1:0]  rd_rem_q;

	always_ff @(posedge clk) begin
		if (wr_int_en) begin
			int_mem[wr_idx] <= wr_int;
		end
		if (wr_rem_en) begin
			rem_mem[wr_idx] <= wr_rem;
		end
		rd_int_q <= int_mem[rd_idx];
		rd_rem_q <= rem_mem[rd_idx];
	end

	assign rd_int = rd_int_q;
	assign rd_rem = rd_rem_q;

endmodule

### dv/timer_cmd_pkg.sv
// timer_cmd_pkg: request command codes shared by the timer queue testbench files.
// Depends on stq_pkg for the command width.
package timer_cmd_pkg;

	typedef enum logic [stq_pkg::CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_START  = 2'd1,
		CMD_STOP   = 2'd2,
		CMD_UNUSED = 2'd3
	} timer_cmd_e;

endpackage

### dv/timer_queue_checker.sv
// timer_queue_checker: watches requests and firings of sorted_timer_queue_unit, keeps its
// own sorted expiry list and compares every firing with the prediction.
// Depends on stq_pkg and timer_cmd_pkg.
module timer_queue_checker
	import stq_pkg::*;
	import timer_cmd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [CMD_W-1:0]       command,
	input  logic [ID_W-1:0]        timer_id,
	input  logic [PERIOD_W-1:0]    period_ms,
	input  logic [PERIOD_W-1:0]    delay_ms,
	input  logic signed [COUNT_W-1:0] repeat_count,
	input  logic                   done,
	input  logic [ID_W-1:0]        fired_timer,
	input  logic [FIRE_TIME_W-1:0] fire_time,
	input  logic                   went_idle,
	output int                     pending,
	output int                     mismatches,
	output int                     firings
);

	typedef struct {
		logic [ID_W-1:0]        id;
		logic [FIRE_TIME_W-1:0] at;
		logic                   last;
	} firing_t;

	firing_t                expected_firings[$];
	logic [FIRE_TIME_W-1:0] now_ms;
	logic [ID_W-1:0]        slot_id  [ID_SPAN];
	logic [FIRE_TIME_W-1:0] slot_due [ID_SPAN];
	int                     slot_count;
	logic [PERIOD_W-1:0]    interval_ms  [ID_SPAN];
	logic [COUNT_W-1:0]     firings_left [ID_SPAN];

	initial begin
		mismatches = 0;
		firings    = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 30)
			$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic void clear_model();
		expected_firings.delete();
		now_ms     = '0;
		slot_count = 0;
		for (int i = 0; i < ID_SPAN; i++) begin
			slot_id[i]      = '0;
			slot_due[i]     = '0;
			interval_ms[i]  = '0;
			firings_left[i] = '0;
		end
	endfunction

	// close the gap left by entry pos
	function automatic void remove_slot(input int pos);
		for (int j = pos; j + 1 < slot_count; j++) begin
			slot_id[j]  = slot_id[j + 1];
			slot_due[j] = slot_due[j + 1];
		end
		slot_count--;
	endfunction

	function automatic void unlink_timer(input logic [ID_W-1:0] id);
		for (int i = 0; i < slot_count; i++) begin
			if (slot_id[i] == id) begin
				remove_slot(i);
				return;
			end
		end
	endfunction

	// equal expiries keep arrival order: new entry goes behind them
	function automatic void insert_sorted(input logic [ID_W-1:0] id,
			input logic [FIRE_TIME_W-1:0] due);
		int pos;
		pos = 0;
		if (slot_count >= ID_SPAN)
			return;
		while (pos < slot_count && slot_due[pos] <= due)
			pos++;
		for (int j = slot_count; j > pos; j--) begin
			slot_id[j]  = slot_id[j - 1];
			slot_due[j] = slot_due[j - 1];
		end
		slot_id[pos]  = id;
		slot_due[pos] = due;
		slot_count++;
	endfunction

	function automatic void predict_request(input timer_cmd_e cmd, input logic [ID_W-1:0] id,
			input logic [PERIOD_W-1:0] per, input logic [PERIOD_W-1:0] dly,
			input logic [COUNT_W-1:0] cnt);
		logic [ID_W-1:0]    t;
		logic [COUNT_W-1:0] left;
		logic               last;
		case (cmd)
			CMD_START: begin
				if (cnt == '0)
					return;
				unlink_timer(id);
				interval_ms[id]  = per;
				firings_left[id] = cnt;
				insert_sorted(id, now_ms + FIRE_TIME_W'(dly != '0 ? dly : per));
			end
			CMD_STOP:
				firings_left[id] = '0;
			CMD_TICK: begin
				now_ms = now_ms + 1'b1;
				if (slot_count == 0 || slot_due[0] > now_ms)
					return;
				t    = slot_id[0];
				left = firings_left[t];
				remove_slot(0);
				// stopped entry expires without a result
				if (left == '0)
					return;
				if (left[COUNT_W-1]) begin
					last = 1'b0;
				end else begin
					left            = left - 1'b1;
					firings_left[t] = left;
					last            = (left == '0);
				end
				if (!last)
					insert_sorted(t, now_ms + FIRE_TIME_W'(interval_ms[t]));
				expected_firings.push_back('{id: t, at: now_ms, last: last});
			end
			default: ;
		endcase
	endfunction

	task automatic check_firing();
		firing_t exp;
		firings++;
		if (expected_firings.size() == 0) begin
			report_mismatch($sformatf("timer %0d fired with no firing predicted", fired_timer));
			return;
		end
		exp = expected_firings.pop_front();
		if (fired_timer !== exp.id)
			report_mismatch($sformatf("fired_timer %0d, predicted %0d", fired_timer, exp.id));
		if (fire_time !== exp.at)
			report_mismatch($sformatf("fire_time %0d, predicted %0d", fire_time, exp.at));
		if (went_idle !== exp.last)
			report_mismatch($sformatf("went_idle %0b, predicted %0b", went_idle, exp.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			pending <= 0;
		end else begin
			if (done === 1'b1)
				check_firing();
			if (start && !busy)
				predict_request(timer_cmd_e'(command), timer_id, period_ms, delay_ms,
					repeat_count);
			pending <= expected_firings.size();
		end
	end

endmodule

### dv/sorted_timer_queue_unit_tb.sv
// sorted_timer_queue_unit_tb: drives directed and random tick, start and stop requests
// into sorted_timer_queue_unit; timer_queue_checker does the prediction and comparison.
// Depends on stq_pkg, timer_cmd_pkg, timer_queue_checker and the unit itself.
module sorted_timer_queue_unit_tb;
	import stq_pkg::*;
	import timer_cmd_pkg::*;

	localparam int RANDOM_ITEMS = 1425;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      start        = 1'b0;
	logic [CMD_W-1:0]          command      = '0;
	logic [ID_W-1:0]           timer_id     = '0;
	logic [PERIOD_W-1:0]       period_ms    = '0;
	logic [PERIOD_W-1:0]       delay_ms     = '0;
	logic signed [COUNT_W-1:0] repeat_count = '0;
	logic                      busy;
	logic                      done;
	logic [ID_W-1:0]           fired_timer;
	logic [FIRE_TIME_W-1:0]    fire_time;
	logic                      went_idle;

	int pending;
	int mismatches;
	int firings;
	int stall_cycles = 0;
	int n_tick = 0, n_start = 0, n_stop = 0, n_unused = 0;
	bit no_idle = 1'b0;

	sorted_timer_queue_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.timer_id(timer_id), .period_ms(period_ms), .delay_ms(delay_ms),
		.repeat_count(repeat_count), .done(done), .fired_timer(fired_timer),
		.fire_time(fire_time), .went_idle(went_idle)
	);

	timer_queue_checker queue_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.timer_id(timer_id), .period_ms(period_ms), .delay_ms(delay_ms),
		.repeat_count(repeat_count), .done(done), .fired_timer(fired_timer),
		.fire_time(fire_time), .went_idle(went_idle), .pending(pending),
		.mismatches(mismatches), .firings(firings)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done === 1'b1)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
				$display("FAIL sorted_timer_queue_unit");
				$finish;
			end
		end
	end

	// hold: wait until every predicted firing has come out before this request
	task automatic send_request(input timer_cmd_e cmd, input logic [ID_W-1:0] id,
			input logic [PERIOD_W-1:0] per, input logic [PERIOD_W-1:0] dly,
			input logic signed [COUNT_W-1:0] cnt, input bit hold);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (hold || gap > 0) begin
			start <= 1'b0;
			if (hold) begin
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		command      <= cmd;
		timer_id     <= id;
		period_ms    <= per;
		delay_ms     <= dly;
		repeat_count <= cnt;
		do
			@(posedge clk);
		while (busy);
		case (cmd)
			CMD_TICK:  n_tick++;
			CMD_START: n_start++;
			CMD_STOP:  n_stop++;
			default:   n_unused++;
		endcase
	endtask

	task automatic send_random();
		timer_cmd_e                cmd;
		logic [PERIOD_W-1:0]       per;
		logic [PERIOD_W-1:0]       dly;
		logic signed [COUNT_W-1:0] cnt;
		int                        r;
		r = $urandom_range(0, 99);
		cmd = r < 55 ? CMD_TICK : r < 80 ? CMD_START : r < 93 ? CMD_STOP : CMD_UNUSED;
		if (cmd != CMD_START) begin
			send_request(cmd, ID_W'($urandom_range(0, 15)), $urandom, $urandom,
				COUNT_W'($urandom), $urandom_range(0, 96) == 0);
			return;
		end
		// short periods and delays keep firings frequent, a few use the full range
		per = $urandom_range(0, 19) == 0 ? $urandom : $urandom_range(0, 12);
		r = $urandom_range(0, 19);
		dly = r < 10 ? '0 : r < 19 ? PERIOD_W'($urandom_range(1, 10)) : $urandom;
		r = $urandom_range(0, 19);
		cnt = r < 3 ? -16'sd1 : r == 3 ? COUNT_W'($urandom) : r == 4 ? '0
			: COUNT_W'($urandom_range(1, 6));
		send_request(cmd, ID_W'($urandom_range(0, 15)), per, dly, cnt, 1'b0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_TICK,   0, 0, 0, 0, 1'b0);
		// zero period and delay: fires on the very next tick
		send_request(CMD_START,  0, 0, 0, 1, 1'b0);
		send_request(CMD_TICK,   0, 0, 0, 0, 1'b0);
		send_request(CMD_START,  1, 5, 0, 0, 1'b0);
		send_request(CMD_START,  2, '1, '1, 16'sh7fff, 1'b0);
		send_request(CMD_START, 15, 2, 1, -16'sd1, 1'b0);
		send_request(CMD_START,  3, 1, 0, 2, 1'b0);
		send_request(CMD_START,  4, 1, 0, 2, 1'b0);
		// restart of a queued timer replaces its entry
		send_request(CMD_START,  3, 4, 2, 3, 1'b0);
		send_request(CMD_STOP,   6, 0, 0, 0, 1'b0);
		send_request(CMD_STOP,   4, 0, 0, 0, 1'b0);
		send_request(CMD_UNUSED, 7, '1, '1, -16'sd1, 1'b0);
		// two expiries on the same tick, only one pop per tick
		send_request(CMD_START,  5, 0, 3, 1, 1'b0);
		send_request(CMD_START,  6, 0, 3, 1, 1'b0);
		for (int i = 0; i < 8; i++)
			send_request(CMD_TICK, 0, 0, 0, 0, i == 4);
		send_request(CMD_STOP,  15, 0, 0, 0, 1'b0);
		send_request(CMD_TICK,   0, 0, 0, 0, 1'b0);
		send_request(CMD_TICK,   0, 0, 0, 0, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			send_random();
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d ticks, %0d starts, %0d stops, %0d unused codes",
			n_tick + n_start + n_stop + n_unused, n_tick, n_start, n_stop, n_unused);
		$display("%0d firings compared, %0d mismatches", firings, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("PASS sorted_timer_queue_unit");
		else
			$display("FAIL sorted_timer_queue_unit");
		$finish;
	end

endmodule

### sorted_timer_queue_unit.f
rtl/core/stq_pkg.sv
rtl/core/stq_cell.sv
rtl/core/stq_timer_mem.sv
rtl/core/sorted_timer_queue_unit.sv
dv/timer_cmd_pkg.sv
dv/timer_queue_checker.sv
dv/sorted_timer_queue_unit_tb.sv
